/* rtl/smsc_pkg.sv */
`default_nettype none
package smsc_pkg;

  localparam logic [31:0] SPV_MAGIC = 32'h0723_0203;
  localparam logic [15:0] OP_ENTRY  = 16'd15;
  localparam logic [15:0] OP_FUNC   = 16'd54;
  localparam logic [15:0] OP_VAR    = 16'd59;
  localparam logic [2:0]  HDR_WORDS = 3'd5;
  localparam int          OUT_CNT_W = 20;
  localparam int          QDEPTH    = 4;
  localparam int          QPTR_W    = 2;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SHORT    = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_RESERVED = 3'd2,
    ERR_BOUND    = 3'd3,
    ERR_ZERO_WC  = 3'd4,
    ERR_TRUNC    = 3'd5,
    ERR_ENTRY    = 3'd6,
    ERR_NAME     = 3'd7
  } err_t;

  typedef struct packed {
    kind_t                 kind;
    err_t                  err_code;
    logic [31:0]           exec_model;
    logic [31:0]           entry_id;
    logic [31:0]           version_out;
    logic [31:0]           generator_out;
    logic [31:0]           bound_out;
    logic [OUT_CNT_W-1:0]  instr_total;
    logic [OUT_CNT_W-1:0]  var_total;
    logic [OUT_CNT_W-1:0]  func_total;
    logic [OUT_CNT_W-1:0]  entry_total;
    logic                  run_last;
  } res_t;

  // results raised by one word, in delivery order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage
`default_nettype wire

/* rtl/smsc_in_if.sv */
`default_nettype none
interface smsc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface
`default_nettype wire

/* rtl/smsc_out_if.sv */
`default_nettype none
interface smsc_out_if
  import smsc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [2:0]           err_code;
  logic [31:0]          exec_model;
  logic [31:0]          entry_id;
  logic [31:0]          version_out;
  logic [31:0]          generator_out;
  logic [31:0]          bound_out;
  logic [OUT_CNT_W-1:0] instr_total;
  logic [OUT_CNT_W-1:0] var_total;
  logic [OUT_CNT_W-1:0] func_total;
  logic [OUT_CNT_W-1:0] entry_total;
  logic                 run_last;

  modport source (
    output valid, output kind, output err_code, output exec_model, output entry_id,
    output version_out, output generator_out, output bound_out, output instr_total,
    output var_total, output func_total, output entry_total, output run_last,
    input ready
  );
  modport sink (
    input valid, input kind, input err_code, input exec_model, input entry_id,
    input version_out, input generator_out, input bound_out, input instr_total,
    input var_total, input func_total, input entry_total, input run_last,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/smsc_parse.sv */
`default_nettype none
module smsc_parse
  import smsc_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [31:0] word,
  input  wire logic        last_word,
  output push_t            push
);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  logic [2:0]  hpos_r, hpos_nxt;
  logic        magic_r, magic_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] ilen_r, ilen_nxt;
  logic [15:0] ipos_r, ipos_nxt;
  logic [15:0] op_r, op_nxt;
  logic [31:0] em_r, em_nxt;
  logic [31:0] id_r, id_nxt;
  logic        nf_r, nf_nxt;
  logic        nul_r, nul_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [31:0] gen_r, gen_nxt;
  logic [31:0] bound_r, bound_nxt;
  cnt_t        cinstr_r, cinstr_nxt;
  cnt_t        cvar_r, cvar_nxt;
  cnt_t        cfunc_r, cfunc_nxt;
  cnt_t        centry_r, centry_nxt;

  res_t        ev, sum;
  logic        ev_valid, sum_valid;
  logic        first_w, zero_byte;
  logic [15:0] len_e, op_e, pos_inc;

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] cnt_out(cnt_t c);
    logic [COUNT_BITS+OUT_CNT_W-1:0] e;
    e = (COUNT_BITS+OUT_CNT_W)'(c);
    return e[OUT_CNT_W-1:0];
  endfunction

  assign first_w   = (ipos_r == 16'd0);
  assign zero_byte = (word[7:0] == 8'd0) || (word[15:8] == 8'd0) ||
                     (word[23:16] == 8'd0) || (word[31:24] == 8'd0);
  assign len_e     = first_w ? word[31:16] : ilen_r;
  assign op_e      = first_w ? word[15:0] : op_r;
  assign pos_inc   = ipos_r + 16'd1;

  always_comb begin
    hpos_nxt = hpos_r;     magic_nxt = magic_r;   failed_nxt = failed_r;
    ilen_nxt = ilen_r;     ipos_nxt = ipos_r;     op_nxt = op_r;
    em_nxt = em_r;         id_nxt = id_r;
    nf_nxt = nf_r;         nul_nxt = nul_r;
    ver_nxt = ver_r;       gen_nxt = gen_r;       bound_nxt = bound_r;
    cinstr_nxt = cinstr_r; cvar_nxt = cvar_r;
    cfunc_nxt = cfunc_r;   centry_nxt = centry_r;
    ev = '0;
    ev_valid = 1'b0;
    sum_valid = 1'b0;

    if (failed_r) begin
      // discarding until the final word
    end else if (hpos_r < HDR_WORDS) begin
      hpos_nxt = hpos_r + 3'd1;
      unique case (hpos_r)
        3'd0: magic_nxt = (word == SPV_MAGIC);
        3'd1: ver_nxt = word;
        3'd2: gen_nxt = word;
        3'd3: bound_nxt = word;
        default: ;
      endcase
      if (hpos_r == HDR_WORDS - 3'd1) begin
        priority if (!magic_r) begin
          ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_MAGIC;
        end else if (word != 32'd0) begin
          ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_RESERVED;
        end else if (bound_r == 32'd0) begin
          ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_BOUND;
        end else begin
          sum_valid = last_word;
        end
      end else if (last_word) begin
        ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_SHORT;
      end
      failed_nxt = ev_valid;
    end else begin
      ilen_nxt = len_e;
      op_nxt   = op_e;
      if (first_w) begin
        nf_nxt  = 1'b0;
        nul_nxt = 1'b0;
      end else if (op_r == OP_ENTRY) begin
        if (ipos_r == 16'd1) begin
          em_nxt = word;
        end else if (ipos_r == 16'd2) begin
          id_nxt = word;
        end else begin
          if (ipos_r == 16'd3) begin
            nf_nxt = (word[7:0] != 8'd0);
          end
          if (zero_byte) begin
            nul_nxt = 1'b1;
          end
        end
      end

      if (first_w && len_e == 16'd0) begin
        ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_ZERO_WC;
      end else if (pos_inc >= len_e) begin
        ipos_nxt   = 16'd0;
        cinstr_nxt = sat_inc(cinstr_r);
        if (op_e == OP_ENTRY) begin
          priority if (len_e < 16'd4) begin
            ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_ENTRY;
          end else if (!nf_nxt || !nul_nxt) begin
            ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_NAME;
          end else begin
            ev_valid      = 1'b1;
            ev.kind       = KIND_ENTRY;
            ev.exec_model = em_nxt;
            ev.entry_id   = id_nxt;
            centry_nxt    = sat_inc(centry_r);
          end
        end else if (op_e == OP_VAR) begin
          cvar_nxt = sat_inc(cvar_r);
        end else if (op_e == OP_FUNC) begin
          cfunc_nxt = sat_inc(cfunc_r);
        end
        sum_valid = last_word && !(ev_valid && ev.kind == KIND_ERROR);
      end else begin
        ipos_nxt = pos_inc;
        if (last_word) begin
          ev_valid = 1'b1; ev.kind = KIND_ERROR; ev.err_code = ERR_TRUNC;
        end
      end
      failed_nxt = ev_valid && (ev.kind == KIND_ERROR);
    end

    sum               = '0;
    sum.kind          = KIND_SUMMARY;
    sum.version_out   = ver_r;
    sum.generator_out = gen_r;
    sum.bound_out     = bound_r;
    sum.instr_total   = cnt_out(cinstr_nxt);
    sum.var_total     = cnt_out(cvar_nxt);
    sum.func_total    = cnt_out(cfunc_nxt);
    sum.entry_total   = cnt_out(centry_nxt);
    sum.run_last      = 1'b1;

    // final word: next word opens a fresh module
    if (last_word) begin
      hpos_nxt = '0;  magic_nxt = 1'b0; failed_nxt = 1'b0;
      ilen_nxt = '0;  ipos_nxt = '0;    op_nxt = '0;
      em_nxt = '0;    id_nxt = '0;      nf_nxt = 1'b0;   nul_nxt = 1'b0;
      ver_nxt = '0;   gen_nxt = '0;     bound_nxt = '0;
      cinstr_nxt = '0; cvar_nxt = '0;   cfunc_nxt = '0;  centry_nxt = '0;
    end
  end

  always_comb begin
    push = '0;
    if (take) begin
      priority if (ev_valid && sum_valid) begin
        push.cnt            = 2'd2;
        push.first          = ev;
        push.first.run_last = 1'b0;
        push.second         = sum;
      end else if (ev_valid) begin
        push.cnt            = 2'd1;
        push.first          = ev;
        push.first.run_last = 1'b1;
      end else if (sum_valid) begin
        push.cnt            = 2'd1;
        push.first          = sum;
      end else begin
        push.cnt            = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpos_r <= '0;  magic_r <= 1'b0; failed_r <= 1'b0;
      ilen_r <= '0;  ipos_r <= '0;    op_r <= '0;
      em_r <= '0;    id_r <= '0;      nf_r <= 1'b0;   nul_r <= 1'b0;
      ver_r <= '0;   gen_r <= '0;     bound_r <= '0;
      cinstr_r <= '0; cvar_r <= '0;   cfunc_r <= '0;  centry_r <= '0;
    end else if (take) begin
      hpos_r <= hpos_nxt;  magic_r <= magic_nxt; failed_r <= failed_nxt;
      ilen_r <= ilen_nxt;  ipos_r <= ipos_nxt;   op_r <= op_nxt;
      em_r <= em_nxt;      id_r <= id_nxt;       nf_r <= nf_nxt;  nul_r <= nul_nxt;
      ver_r <= ver_nxt;    gen_r <= gen_nxt;     bound_r <= bound_nxt;
      cinstr_r <= cinstr_nxt; cvar_r <= cvar_nxt;
      cfunc_r <= cfunc_nxt;   centry_r <= centry_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && last_word |=> hpos_r == 3'd0 && !failed_r)
    else $error("final word did not restart the module");
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take && failed_r |-> push.cnt == 2'd0)
    else $error("result raised while discarding");
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.first.kind == KIND_ENTRY && push.second.kind == KIND_SUMMARY)
    else $error("two results that are not entry then summary");
  a_hpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hpos_r <= HDR_WORDS)
    else $error("header position out of range");
`endif

endmodule
`default_nettype wire

/* rtl/smsc_outq.sv */
`default_nettype none
module smsc_outq
  import smsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space_ok,
  smsc_out_if.source out_ch
);

  res_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, rd_r;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;
  logic               pop;
  res_t               head;

  assign pop      = out_ch.valid && out_ch.ready;
  assign space_ok = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));
  assign cnt_nxt  = cnt_r + (QPTR_W+1)'(push.cnt) - (QPTR_W+1)'(pop);
  assign head     = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_r + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QPTR_W'(push.cnt);
      rd_r  <= rd_r + QPTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.kind          = head.kind;
  assign out_ch.err_code      = head.err_code;
  assign out_ch.exec_model    = head.exec_model;
  assign out_ch.entry_id      = head.entry_id;
  assign out_ch.version_out   = head.version_out;
  assign out_ch.generator_out = head.generator_out;
  assign out_ch.bound_out     = head.bound_out;
  assign out_ch.instr_total   = head.instr_total;
  assign out_ch.var_total     = head.var_total;
  assign out_ch.func_total    = head.func_total;
  assign out_ch.entry_total   = head.entry_total;
  assign out_ch.run_last      = head.run_last;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("result queue overflow");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r == rd_r + cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with fill count");
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(head))
    else $error("waiting result changed or dropped");
`endif

endmodule
`default_nettype wire

/* rtl/spirv_module_scanner.sv */
`default_nettype none
// Scans a SPIR-V module presented one word per request, final word flagged.
// Each word is taken into an input register and then processed, when the
// queue has room, by the header and instruction-framing logic, which writes
// its results (an entry-point record, a summary or an error, at most two per
// word) into a four-entry result queue. A new word is taken every cycle
// while the queue has at least two free slots, so the sustained rate is one
// word per cycle as long as results are drained at least as fast as they
// arise; a final word that closes an entry point yields two results. A
// word's results are shown from the queue after the word has passed the
// input register. Counters are COUNT_BITS wide and saturate; totals are
// reported in 20 bits.
module spirv_module_scanner
  import smsc_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  smsc_in_if.sink    in_ch,
  smsc_out_if.source out_ch
);

  logic        s_valid_r;
  logic [31:0] s_word_r;
  logic        s_last_r;
  logic        space_ok;
  logic        take;
  push_t       push;

  assign take        = s_valid_r && space_ok;
  assign in_ch.ready = !s_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s_valid_r <= 1'b1;
    end else if (take) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_word_r <= in_ch.word;
      s_last_r <= in_ch.last_word;
    end
  end

  smsc_parse #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .word      (s_word_r),
    .last_word (s_last_r),
    .push      (push)
  );

  smsc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
